[src/csvt_pkg.sv]
// Package for the CSV cell tokenizer: result item types, kind codes and sizing constants.
// Depends on nothing; every other file of the block imports it.

package csvt_pkg;

   // Characters that steer the tokenizer.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // One input byte causes at most this many result items.
   localparam int MAX_RES   = 3;
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);
   localparam int RES_IDX_W = $clog2(MAX_RES);

   // Default depth of the result queue.
   localparam int RSPQ_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_CELL      = 2'd1,
      KIND_CELL_LINE = 2'd2,
      KIND_LINE      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } item_type;

   // Everything one accepted byte produces, handed from the tokenizer to the queue.
   typedef struct packed {
      logic [RES_CNT_W-1:0]         count;
      item_type [MAX_RES-1:0]       items;
   } step_out_type;

endpackage

[src/csvt_step.sv]
// Tokenizer state machine: holds the parse state and line flag and, for one byte,
// works out the result items it causes. Depends on csvt_pkg.

module csvt_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_fire,
   input  logic [7:0]            in_byte,
   input  logic                  in_end,
   output csvt_pkg::step_out_type step_out
);
   import csvt_pkg::*;

   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_UNQ     = 3'd1,
      ST_UNQ_CR  = 3'd2,
      ST_QUO     = 3'd3,
      ST_QUO_Q   = 3'd4,
      ST_QUO_QCR = 3'd5
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic            line_open_ff, line_open_in;

   always_comb begin
      logic [RES_CNT_W-1:0]   n;
      item_type [MAX_RES-1:0] items;
      logic                   unq_path;
      logic                   quo_path;

      n            = '0;
      items        = '0;
      unq_path     = 1'b0;
      quo_path     = 1'b0;
      state_in     = state_ff;
      line_open_in = line_open_ff;

      case (state_ff)
         ST_UNQ: begin
            unq_path = 1'b1;
         end
         ST_UNQ_CR: begin
            if (in_byte == CH_LF) begin
               items[n[RES_IDX_W-1:0]].kind = KIND_CELL_LINE;
               n = n + 1'b1;
               line_open_in = 1'b0;
               state_in = ST_START;
            end else begin
               // The held CR was not the start of a line break, so it is content.
               items[n[RES_IDX_W-1:0]].kind = KIND_DATA;
               items[n[RES_IDX_W-1:0]].data = CH_CR;
               n = n + 1'b1;
               unq_path = 1'b1;
            end
         end
         ST_QUO: begin
            quo_path = 1'b1;
         end
         ST_QUO_Q: begin
            if (in_byte == CH_COMMA) begin
               items[n[RES_IDX_W-1:0]].kind = KIND_CELL;
               n = n + 1'b1;
               line_open_in = 1'b1;
               state_in = ST_START;
            end else if (in_byte == CH_CR) begin
               state_in = ST_QUO_QCR;
            end else begin
               items[n[RES_IDX_W-1:0]].kind = KIND_DATA;
               items[n[RES_IDX_W-1:0]].data = in_byte;
               n = n + 1'b1;
               state_in = ST_QUO;
            end
         end
         ST_QUO_QCR: begin
            if (in_byte == CH_LF) begin
               items[n[RES_IDX_W-1:0]].kind = KIND_CELL_LINE;
               n = n + 1'b1;
               line_open_in = 1'b0;
               state_in = ST_START;
            end else begin
               items[n[RES_IDX_W-1:0]].kind = KIND_DATA;
               items[n[RES_IDX_W-1:0]].data = CH_CR;
               n = n + 1'b1;
               quo_path = 1'b1;
            end
         end
         default: begin
            if (in_byte == CH_QUOTE) begin
               state_in = ST_QUO;
            end else begin
               unq_path = 1'b1;
            end
         end
      endcase

      if (unq_path) begin
         if (in_byte == CH_COMMA) begin
            items[n[RES_IDX_W-1:0]].kind = KIND_CELL;
            n = n + 1'b1;
            line_open_in = 1'b1;
            state_in = ST_START;
         end else if (in_byte == CH_CR) begin
            state_in = ST_UNQ_CR;
         end else begin
            items[n[RES_IDX_W-1:0]].kind = KIND_DATA;
            items[n[RES_IDX_W-1:0]].data = in_byte;
            n = n + 1'b1;
            state_in = ST_UNQ;
         end
      end

      if (quo_path) begin
         if (in_byte == CH_QUOTE) begin
            state_in = ST_QUO_Q;
         end else begin
            items[n[RES_IDX_W-1:0]].kind = KIND_DATA;
            items[n[RES_IDX_W-1:0]].data = in_byte;
            n = n + 1'b1;
            state_in = ST_QUO;
         end
      end

      // At the end of the file any held CR becomes content and the open cell and line close.
      if (in_end) begin
         case (state_in)
            ST_UNQ_CR, ST_QUO_QCR: begin
               items[n[RES_IDX_W-1:0]].kind = KIND_DATA;
               items[n[RES_IDX_W-1:0]].data = CH_CR;
               n = n + 1'b1;
               items[n[RES_IDX_W-1:0]].kind = KIND_CELL_LINE;
               n = n + 1'b1;
            end
            ST_UNQ, ST_QUO, ST_QUO_Q: begin
               items[n[RES_IDX_W-1:0]].kind = KIND_CELL_LINE;
               n = n + 1'b1;
            end
            default: begin
               if (line_open_in) begin
                  items[n[RES_IDX_W-1:0]].kind = KIND_LINE;
                  n = n + 1'b1;
               end
            end
         endcase
         state_in     = ST_START;
         line_open_in = 1'b0;
      end

      if (n != '0) begin
         items[RES_IDX_W'(n - 1'b1)].last = 1'b1;
      end

      step_out.count = n;
      step_out.items = items;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         line_open_ff <= 1'b0;
      end else if (in_fire) begin
         state_ff     <= state_in;
         line_open_ff <= line_open_in;
      end
   end

endmodule

[src/csvt_rspq.sv]
// Result queue: takes up to three result items in a cycle and hands out one per cycle while pop is asserted.
// Depends on csvt_pkg.

module csvt_rspq #(
   parameter int DEPTH = csvt_pkg::RSPQ_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_en,
   input  csvt_pkg::step_out_type       push,
   input  logic                         pop,
   output csvt_pkg::item_type           head,
   output logic                         head_valid,
   output logic                         has_room,
   output logic [$clog2(DEPTH+1)-1:0]   level
);
   import csvt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     wr_idx [MAX_RES];
   logic [RES_CNT_W-1:0] push_n;
   logic                 pop_fire;

   assign push_n   = push_en ? push.count : '0;
   assign pop_fire = pop && (count_ff != '0);

   // Slot addresses wrap with one compare and subtract, since the offset stays below DEPTH.
   always_comb begin
      logic [PTR_W:0] sum;
      for (int i = 0; i < MAX_RES; i++) begin
         sum = {1'b0, wr_ptr_ff} + (PTR_W+1)'(i);
         if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
         end
         wr_idx[i] = sum[PTR_W-1:0];
      end
      sum = {1'b0, wr_ptr_ff} + (PTR_W+1)'(push_n);
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      wr_ptr_in = sum[PTR_W-1:0];
      if (!pop_fire) begin
         rd_ptr_in = rd_ptr_ff;
      end else if (rd_ptr_ff == PTR_W'(DEPTH - 1)) begin
         rd_ptr_in = '0;
      end else begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (RES_CNT_W'(i) < push_n) begin
            slots_ff[wr_idx[i]] <= push.items[i];
         end
      end
   end

   assign head       = slots_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign has_room   = (count_ff <= CNT_W'(DEPTH - MAX_RES));
   assign level      = count_ff;

endmodule

[src/csv_cell_tokenizer.sv]
// CSV cell tokenizer: one byte of text in per transfer, content bytes and cell/line marks out.
// Results of a byte are written into the result queue at its transfer and offered on rsp_ in order, behind any held.
// Throughput: one byte per cycle while the result queue has room for three more items;
// a byte with two or three results takes that many transfers on the output side.
// Reset is synchronous and active high; it returns the tokenizer to cell start and empties the queue.
// Depends on csvt_pkg, csvt_step and csvt_rspq.

module csv_cell_tokenizer #(
   parameter int RSP_DEPTH = csvt_pkg::RSPQ_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_of_run
);
   import csvt_pkg::*;

   step_out_type                   step_out;
   item_type                       head;
   logic                           req_fire;
   logic                           q_room;
   logic [$clog2(RSP_DEPTH+1)-1:0] q_level;

   // A byte is taken whenever the queue could absorb the worst case of three results,
   // so the input side never waits on the output handshake within the same cycle.
   assign req_ready = q_room;
   assign req_fire  = req_valid && req_ready;

   // The tokenizer works on the byte straight from the input port; its state advances
   // only on a transfer, and all results of the byte land in the queue at the same edge.
   csvt_step u_step (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (req_fire),
      .in_byte  (req_in_byte),
      .in_end   (req_end_of_input),
      .step_out (step_out)
   );

   // The queue registers the results and separates the two handshakes.
   csvt_rspq #(
      .DEPTH (RSP_DEPTH)
   ) u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push_en    (req_fire),
      .push       (step_out),
      .pop        (rsp_ready),
      .head       (head),
      .head_valid (rsp_valid),
      .has_room   (q_room),
      .level      (q_level)
   );

   assign rsp_kind        = head.kind;
   assign rsp_data_byte   = head.data;
   assign rsp_last_of_run = head.last;

   // Marks carry no content byte.
   a_mark_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_DATA)) |-> (rsp_data_byte == 8'd0))
      else $error("cell or line mark carries a non-zero data byte");

   // A transfer that produced results leaves something to offer in the next cycle.
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (step_out.count != '0)) |=> rsp_valid)
      else $error("results of an accepted byte were not offered");

   // The queue never holds more items than it has slots.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_level <= ($clog2(RSP_DEPTH+1))'(RSP_DEPTH))
      else $error("result queue overflow");

endmodule
